@@ sv/bbe_pkg.sv @@
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants for the button bank edge event block
// Register indexes, result kinds, widths and the bundles that pass between
// the register file, the sequencer and the top level.
// ----------------------------------------------------------------------------
package bbe_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int ID_SLOTS    = 8;
   localparam int POS_W       = $clog2(NUM_BUTTONS);
   localparam int ID_W        = 16;
   localparam int RAW_W       = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_MASK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IDS_0_1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDS_2_3     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDS_4_5     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDS_6_7     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_ENABLE = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DOWN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // input ops
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic [RAW_W-1:0]       invert_mask;
      logic                   scan_enable;
      logic [NUM_BUTTONS-1:0] mapped;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   button_id;
      logic              pressed;
      logic              last;
   } evt_type;

endpackage

@@ sv/bbe_csr.sv @@
// ----------------------------------------------------------------------------
// bbe_csr: configuration registers
// Holds the inversion mask, the eight button IDs and the scan enable, and
// looks up the ID of the position the sequencer is visiting.
// ----------------------------------------------------------------------------
module bbe_csr
   import bbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [POS_W-1:0]      pos,
   output logic [ID_W-1:0]       pos_id,
   output cfg_type               cfg
);

   logic [RAW_W-1:0] invert_mask_ff, invert_mask_in;
   logic             scan_enable_ff, scan_enable_in;
   logic [ID_W-1:0]  ids_ff [ID_SLOTS];
   logic [ID_W-1:0]  ids_in [ID_SLOTS];

   assign csr_ready = 1'b1;

   always_comb begin
      invert_mask_in = invert_mask_ff;
      scan_enable_in = scan_enable_ff;
      ids_in         = ids_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_INVERT_MASK: invert_mask_in = csr_wdata[RAW_W-1:0];
            REG_IDS_0_1: begin
               ids_in[0] = csr_wdata[15:0];
               ids_in[1] = csr_wdata[31:16];
            end
            REG_IDS_2_3: begin
               ids_in[2] = csr_wdata[15:0];
               ids_in[3] = csr_wdata[31:16];
            end
            REG_IDS_4_5: begin
               ids_in[4] = csr_wdata[15:0];
               ids_in[5] = csr_wdata[31:16];
            end
            REG_IDS_6_7: begin
               ids_in[6] = csr_wdata[15:0];
               ids_in[7] = csr_wdata[31:16];
            end
            REG_SCAN_ENABLE: scan_enable_in = csr_wdata[0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_mask_ff <= '0;
         scan_enable_ff <= 1'b1;
         for (int i = 0; i < ID_SLOTS; i++) begin
            ids_ff[i] <= '0;
         end
      end else begin
         invert_mask_ff <= invert_mask_in;
         scan_enable_ff <= scan_enable_in;
         ids_ff         <= ids_in;
      end
   end

   always_comb begin
      if (int'(pos) < ID_SLOTS) begin
         pos_id = ids_ff[pos];
      end else begin
         pos_id = '0;
      end
   end

   always_comb begin
      cfg.invert_mask = invert_mask_ff;
      cfg.scan_enable = scan_enable_ff;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         cfg.mapped[i] = (i < ID_SLOTS) ? (ids_ff[i] != '0) : 1'b0;
      end
   end

endmodule

@@ sv/bbe_seq.sv @@
// ----------------------------------------------------------------------------
// bbe_seq: position sequencer
// Walks button positions one per cycle with a single ID comparator, pausing for
// result beats; emits key events for changed mapped bits or answers a pressed query.
// ----------------------------------------------------------------------------
module bbe_seq
   import bbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [RAW_W-1:0] req_raw_bits,
   input  logic [ID_W-1:0]  req_query_id,
   input  cfg_type          cfg,
   input  logic [ID_W-1:0]  pos_id,
   output logic [POS_W-1:0] pos,
   input  logic             out_free,
   output evt_type          evt
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_QUERY = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   phase_ff, phase_in;
   logic [NUM_BUTTONS-1:0] pend_ff, pend_in;
   logic [NUM_BUTTONS-1:0] pressed_ff, pressed_in;
   logic [ID_W-1:0]        qid_ff, qid_in;

   logic [NUM_BUTTONS-1:0] next_bits;
   logic [NUM_BUTTONS-1:0] changed;
   logic [NUM_BUTTONS-1:0] rest;
   logic                   slot_ok;
   logic                   id_eq;
   logic                   end_pos;

   assign pos       = pos_ff;
   assign req_stall = (state_ff != S_IDLE);

   assign next_bits = NUM_BUTTONS'(req_raw_bits ^ cfg.invert_mask);
   assign changed   = (next_bits ^ pressed_ff) & cfg.mapped;
   assign slot_ok   = (int'(pos_ff) < ID_SLOTS);
   // shared comparator: query ID against the visited position's ID
   assign id_eq     = slot_ok && (pos_id == qid_ff);
   assign end_pos   = (pos_ff == POS_W'(NUM_BUTTONS - 1));
   assign rest      = pend_ff & ~(NUM_BUTTONS'(1) << pos_ff);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      pressed_in = pressed_ff;
      qid_in     = qid_ff;
      evt        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in   = '0;
               phase_in = 1'b0;
               if (req_op == OP_QUERY) begin
                  qid_in   = req_query_id;
                  state_in = S_QUERY;
               end else if (cfg.scan_enable && (next_bits != pressed_ff)) begin
                  pressed_in = next_bits;
                  pend_in    = changed;
                  if (changed != '0) begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_QUERY: begin
            if (id_eq || end_pos) begin
               if (out_free) begin
                  evt.valid     = 1'b1;
                  evt.kind      = KIND_QUERY;
                  evt.button_id = qid_ff;
                  evt.pressed   = id_eq & pressed_ff[pos_ff];
                  evt.last      = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (pend_ff[pos_ff]) begin
               if (out_free) begin
                  evt.valid = 1'b1;
                  evt.kind  = pressed_ff[pos_ff] ? KIND_DOWN : KIND_UP;
                  if (!phase_ff) begin
                     evt.button_id = pos_id;
                     phase_in      = 1'b1;
                  end else begin
                     // any-key beat closes this position
                     evt.button_id = '0;
                     evt.last      = (rest == '0);
                     pend_in       = rest;
                     phase_in      = 1'b0;
                     pos_in        = pos_ff + 1'b1;
                     if (rest == '0) begin
                        state_in = S_IDLE;
                     end
                  end
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= '0;
         phase_ff   <= 1'b0;
         pend_ff    <= '0;
         pressed_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         pressed_ff <= pressed_in;
      end
      qid_ff <= qid_in;
   end

endmodule

@@ sv/button_bank_edge_events_top.sv @@
// A query walks positions one per cycle until its ID matches or the last position is
// reached, then answers with a single beat once the output slot is free. A sample with
// changed mapped bits walks them too and emits a key beat and an any-key beat per bit; up to 16 result beats.
// The position sequencer and its single ID comparator set the rate.
// Reset (synchronous): pressed state 0, IDs 0, inversion mask 0, scanning on.
// ----------------------------------------------------------------------------
// button_bank_edge_events_top: button bank edge event generator
// Turns 8-bit button snapshots into key-down/key-up beats and answers
// pressed queries by button ID.
// ----------------------------------------------------------------------------
module button_bank_edge_events_top
   import bbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [RAW_W-1:0]      req_raw_bits,
   input  logic [ID_W-1:0]       req_query_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [ID_W-1:0]       rsp_button_id,
   output logic                  rsp_pressed,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg;
   evt_type          evt;
   logic [POS_W-1:0] pos;
   logic [ID_W-1:0]  pos_id;
   logic             out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_pressed_ff;
   logic              rsp_last_ff;

   bbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pos       (pos),
      .pos_id    (pos_id),
      .cfg       (cfg)
   );

   bbe_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_raw_bits (req_raw_bits),
      .req_query_id (req_query_id),
      .cfg          (cfg),
      .pos_id       (pos_id),
      .pos          (pos),
      .out_free     (out_free),
      .evt          (evt)
   );

   // output slot frees when empty or when its beat is taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (evt.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (evt.valid) begin
         rsp_kind_ff    <= evt.kind;
         rsp_id_ff      <= evt.button_id;
         rsp_pressed_ff <= evt.pressed;
         rsp_last_ff    <= evt.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_button_id = rsp_id_ff;
   assign rsp_pressed   = rsp_pressed_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ sv/bbe_checker.sv @@
// ----------------------------------------------------------------------------
// bbe_checker: port-level checks for the button bank edge event block
// Watches request, result and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module bbe_checker
   import bbe_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_op,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [ID_W-1:0]   rsp_button_id,
   input logic              rsp_pressed,
   input logic              rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_button_id) && $stable(rsp_pressed) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // a query answer is always the only beat of its item
   a_query_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_QUERY) |-> rsp_last)
      else $error("query answer without last");

   // key events carry pressed low
   a_event_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_QUERY) |-> !rsp_pressed)
      else $error("key event with pressed set");

   // an accepted query keeps the block busy in the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_QUERY) |=> req_stall)
      else $error("block ready right after a query");

   // no result beat straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind button_bank_edge_events_top bbe_checker u_bbe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_button_id (rsp_button_id),
   .rsp_pressed   (rsp_pressed),
   .rsp_last      (rsp_last)
);
